[rtl/core/mms_pkg.sv]
// mms_pkg: shared types, constants and helper functions of the mailbox splitter
// used by every module under rtl/core; depends on nothing
`timescale 1ns / 1ps

package mms_pkg;

	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_QUOTE = 8'h3E;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam int unsigned PFX_LEN     = 5;
	localparam int unsigned MMS_Q_DEPTH = 4;

	// one beat of the raw mailbox byte stream
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_file;
	} in_beat_t;

	// one beat of the split message stream
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       message_end;
		logic       last;
	} out_beat_t;

	// work for the back end, in output order:
	// held quote, held prefix letters, held cr, the byte itself, end markers
	typedef struct packed {
		logic       quote;
		logic [2:0] nlet;
		logic       cr;
		logic       has_b;
		logic [7:0] b;
		logic [1:0] nend;
	} cmd_t;

	// letters of the separator prefix "From "
	function automatic logic [7:0] pfx_char(input logic [2:0] idx);
		logic [7:0] c;
		c = CHAR_SPACE;
		unique case (idx)
			3'd0:    c = 8'h46;
			3'd1:    c = 8'h72;
			3'd2:    c = 8'h6F;
			3'd3:    c = 8'h6D;
			default: c = CHAR_SPACE;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/mms_front.sv]
// mms_front: line classifier of the mailbox splitter; keeps the per-line state
// and turns each input byte into at most one command for the back end; uses mms_pkg
`timescale 1ns / 1ps

module mms_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	output logic             stall,
	input  mms_pkg::in_beat_t data,
	output logic             push,
	output mms_pkg::cmd_t    cmd,
	input  logic             full
);
	import mms_pkg::*;

	logic       at_ls_q, pb_q, in_msg_q, in_pfx_q, hq_q, hcr_q, drop_q;
	logic [2:0] mcnt_q;
	logic       at_ls_d, pb_d, in_msg_d, in_pfx_d, hq_d, hcr_d, drop_d;
	logic [2:0] mcnt_d;
	logic       accept;
	logic [7:0] b;
	cmd_t       c;

	assign b      = data.in_byte;
	assign stall  = full;
	assign accept = valid & ~full;
	assign cmd    = c;
	assign push   = accept & (c.quote | (c.nlet != 3'd0) | c.cr | c.has_b | (c.nend != 2'd0));

	always_comb begin
		at_ls_d  = at_ls_q;
		pb_d     = pb_q;
		in_msg_d = in_msg_q;
		in_pfx_d = in_pfx_q;
		hq_d     = hq_q;
		hcr_d    = hcr_q;
		drop_d   = drop_q;
		mcnt_d   = mcnt_q;
		c        = '0;
		c.b      = b;

		if (drop_q) begin
			// rest of a separator line
			if (b == CHAR_LF) begin
				drop_d  = 1'b0;
				at_ls_d = 1'b1;
				pb_d    = 1'b0;
			end
		end else if (hcr_q) begin
			hcr_d = 1'b0;
			if (b == CHAR_LF) begin
				// lone cr line is blank
				if (in_msg_q) begin
					c.cr    = 1'b1;
					c.has_b = 1'b1;
				end
				at_ls_d = 1'b1;
				pb_d    = 1'b1;
			end else begin
				c.cr     = 1'b1;
				c.has_b  = 1'b1;
				in_msg_d = 1'b1;
				at_ls_d  = 1'b0;
			end
		end else if (in_pfx_q) begin
			if (mcnt_q < 3'(PFX_LEN) && b == pfx_char(mcnt_q)) begin
				mcnt_d = mcnt_q + 3'd1;
				if (mcnt_q == 3'(PFX_LEN - 1)) begin
					in_pfx_d = 1'b0;
					mcnt_d   = 3'd0;
					in_msg_d = 1'b1;
					if (hq_q) begin
						// quoted from line: drop one quote, pass the letters
						hq_d   = 1'b0;
						c.nlet = 3'(PFX_LEN);
					end else begin
						if (in_msg_q) c.nend = 2'd1;
						drop_d = 1'b1;
					end
				end
			end else if (hq_q && mcnt_q == 3'd0 && b == CHAR_QUOTE) begin
				c.has_b  = 1'b1;
				in_msg_d = 1'b1;
			end else begin
				// failed prefix: flush held bytes, then the byte as content
				c.quote  = hq_q;
				c.nlet   = mcnt_q;
				c.has_b  = 1'b1;
				in_pfx_d = 1'b0;
				hq_d     = 1'b0;
				mcnt_d   = 3'd0;
				in_msg_d = 1'b1;
				at_ls_d  = (b == CHAR_LF);
				if (b == CHAR_LF) pb_d = 1'b0;
			end
		end else if (at_ls_q && b == CHAR_LF) begin
			if (in_msg_q) c.has_b = 1'b1;
			pb_d = 1'b1;
		end else if (at_ls_q && b == CHAR_CR) begin
			at_ls_d = 1'b0;
			hcr_d   = 1'b1;
		end else if (at_ls_q && b == CHAR_QUOTE) begin
			at_ls_d  = 1'b0;
			in_pfx_d = 1'b1;
			hq_d     = 1'b1;
			mcnt_d   = 3'd0;
		end else if (at_ls_q && b == pfx_char(3'd0) && pb_q) begin
			at_ls_d  = 1'b0;
			in_pfx_d = 1'b1;
			hq_d     = 1'b0;
			mcnt_d   = 3'd1;
		end else begin
			c.has_b  = 1'b1;
			in_msg_d = 1'b1;
			at_ls_d  = (b == CHAR_LF);
			if (b == CHAR_LF) pb_d = 1'b0;
		end

		if (data.end_of_file) begin
			// a cr held here was set by this byte, so nothing else was emitted
			if (hcr_d && in_msg_d) c.cr = 1'b1;
			if (in_pfx_d) begin
				c.quote = c.quote | hq_d;
				c.nlet  = mcnt_d;
				if (hq_d || mcnt_d != 3'd0) in_msg_d = 1'b1;
			end
			if (in_msg_d) c.nend = c.nend + 2'd1;
			at_ls_d  = 1'b1;
			pb_d     = 1'b1;
			in_msg_d = 1'b0;
			in_pfx_d = 1'b0;
			hq_d     = 1'b0;
			hcr_d    = 1'b0;
			drop_d   = 1'b0;
			mcnt_d   = 3'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_ls_q  <= 1'b1;
			pb_q     <= 1'b1;
			in_msg_q <= 1'b0;
			in_pfx_q <= 1'b0;
			hq_q     <= 1'b0;
			hcr_q    <= 1'b0;
			drop_q   <= 1'b0;
			mcnt_q   <= 3'd0;
		end else if (accept) begin
			at_ls_q  <= at_ls_d;
			pb_q     <= pb_d;
			in_msg_q <= in_msg_d;
			in_pfx_q <= in_pfx_d;
			hq_q     <= hq_d;
			hcr_q    <= hcr_d;
			drop_q   <= drop_d;
			mcnt_q   <= mcnt_d;
		end
	end

endmodule

[rtl/core/mms_queue.sv]
// mms_queue: small command fifo between front and back of the mailbox splitter
// register based storage, one push and one pop per cycle; uses mms_pkg
`timescale 1ns / 1ps

module mms_queue #(
	parameter int unsigned DEPTH = mms_pkg::MMS_Q_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mms_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output mms_pkg::cmd_t rd_cmd
);
	import mms_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/mms_back.sv]
// mms_back: expands one queued command into its output beats of the splitter
// one beat per cycle into a registered output while the output is not stalled; uses mms_pkg
`timescale 1ns / 1ps

module mms_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  mms_pkg::cmd_t     cmd,
	output logic              pop,
	output logic              valid,
	input  logic              stall,
	output mms_pkg::out_beat_t data
);
	import mms_pkg::*;

	logic [2:0] step_q;
	logic       valid_q;
	out_beat_t  data_q;
	out_beat_t  beat;
	logic       load;
	logic [3:0] k, e_q, e_l, e_c, e_b, total;
	logic [3:0] lidx;

	assign valid = valid_q;
	assign data  = data_q;
	assign load  = ~valid_q | ~stall;
	assign pop   = load & cmd_valid & beat.last;

	always_comb begin
		k     = {1'b0, step_q};
		e_q   = {3'b0, cmd.quote};
		e_l   = e_q + {1'b0, cmd.nlet};
		e_c   = e_l + {3'b0, cmd.cr};
		e_b   = e_c + {3'b0, cmd.has_b};
		total = e_b + {2'b0, cmd.nend};
		lidx  = k - e_q;
		beat  = '0;
		if (k < e_q) begin
			beat.out_byte = CHAR_QUOTE;
			beat.has_byte = 1'b1;
		end else if (k < e_l) begin
			beat.out_byte = pfx_char(lidx[2:0]);
			beat.has_byte = 1'b1;
		end else if (k < e_c) begin
			beat.out_byte = CHAR_CR;
			beat.has_byte = 1'b1;
		end else if (k < e_b) begin
			beat.out_byte = cmd.b;
			beat.has_byte = 1'b1;
		end else begin
			beat.message_end = 1'b1;
		end
		beat.last = (k + 4'd1 >= total);
	end

	always_ff @(posedge clk) begin
		if (load && cmd_valid) data_q <= beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 3'd0;
		end else if (load) begin
			valid_q <= cmd_valid;
			if (cmd_valid) step_q <= beat.last ? 3'd0 : step_q + 3'd1;
		end
	end

endmodule

[rtl/core/mbox_message_splitter.sv]
// mbox_message_splitter: top level of the streaming mboxrd mailbox splitter
// instantiates mms_front, mms_queue and mms_back; uses mms_pkg
`timescale 1ns / 1ps

//  channel  | direction | beat       | handshake
//  src      | in        | in_beat_t  | src_valid / src_stall
//  dst      | out       | out_beat_t | dst_valid / dst_stall
//
// a raw byte is taken every cycle while the command queue has room
// each byte yields zero to seven output beats, one per cycle from the back end while dst_stall is low
// held prefix flushes and end markers therefore take extra output cycles
// reset returns the line state to file start and empties the queue
// src_stall rises only when the command queue is full

module mbox_message_splitter #(
	parameter int unsigned Q_DEPTH = mms_pkg::MMS_Q_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  mms_pkg::in_beat_t  src_data,
	output logic               dst_valid,
	input  logic               dst_stall,
	output mms_pkg::out_beat_t dst_data
);
	import mms_pkg::*;

	// front to queue
	logic push, full;
	cmd_t wr_cmd;

	// queue to back
	logic pop, not_empty;
	cmd_t rd_cmd;

	// classify each byte against the line state and build its command
	mms_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (src_valid),
		.stall  (src_stall),
		.data   (src_data),
		.push   (push),
		.cmd    (wr_cmd),
		.full   (full)
	);

	// decouples the byte intake from multi beat output bursts
	mms_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_cmd    (rd_cmd)
	);

	// walk each command beat by beat into the output register
	mms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (not_empty),
		.cmd       (rd_cmd),
		.pop       (pop),
		.valid     (dst_valid),
		.stall     (dst_stall),
		.data      (dst_data)
	);

endmodule
